// ===== rtl/column_edges_to_row_spans_core_assert.svh =====
// Assertion macros shared by the column-to-span RTL.
`ifndef COLUMN_EDGES_TO_ROW_SPANS_CORE_ASSERT_SVH
`define COLUMN_EDGES_TO_ROW_SPANS_CORE_ASSERT_SVH

// Condition that must hold at every edge out of reset.
`define CE2RS_ASSERT_HOLDS(label, clk_i, rst_ni, cond, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define CE2RS_ASSERT_IMP(label, clk_i, rst_ni, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CE2RS_ASSERT_NXT(label, clk_i, rst_ni, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ce2rs_pkg.sv =====
// Shared widths, types and helpers for the column-to-span converter.
package ce2rs_pkg;

	localparam int ROWS_DEF = 64;
	localparam int COLUMNS  = 1024;
	localparam int ROW_W    = 6;
	localparam int COL_X_W  = 11;
	localparam int X_W      = $clog2(COLUMNS);
	// row plus one bit so that "no row" sits above every real row
	localparam int WALK_W   = ROW_W + 1;
	localparam logic [WALK_W-1:0] EMPTY_ROW = {1'b1, {ROW_W{1'b0}}};

	typedef enum logic [2:0] {
		WS_IDLE,
		WS_CLOSE_TOP,
		WS_CLOSE_BOT,
		WS_OPEN_TOP,
		WS_OPEN_BOT
	} walk_state_t;

	// span request from walker to output stage
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [X_W-1:0]   x_final;
		logic             last;
	} emit_req_t;

	function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] v,
		input logic [ROW_W-1:0] lim);
		return (v > lim) ? lim : v;
	endfunction

endpackage

// ===== rtl/ce2rs_col_if.sv =====
// Column word channel.
interface ce2rs_col_if;
	import ce2rs_pkg::*;

	logic               valid;
	logic               ready;
	logic [COL_X_W-1:0] column_x;
	logic [ROW_W-1:0]   top_row;
	logic [ROW_W-1:0]   bottom_row;
	logic               column_empty;
	logic               plane_start;

	modport source(output valid, column_x, top_row, bottom_row, column_empty, plane_start,
		input ready);
	modport sink(input valid, column_x, top_row, bottom_row, column_empty, plane_start,
		output ready);
endinterface

// ===== rtl/ce2rs_span_if.sv =====
// Span word channel.
interface ce2rs_span_if;
	import ce2rs_pkg::*;

	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] span_row;
	logic [X_W-1:0]   span_x_first;
	logic [X_W-1:0]   span_x_final;
	logic             span_last;

	modport source(output valid, span_row, span_x_first, span_x_final, span_last,
		input ready);
	modport sink(input valid, span_row, span_x_first, span_x_final, span_last,
		output ready);
endinterface

// ===== rtl/column_edges_to_row_spans_core.sv =====
// Column edges to row spans: top level.
//
// Input channel col: one word per screen column of a plane, left to right
// (column_x, top_row, bottom_row, column_empty, plane_start). plane_start
// marks the first column; a closing empty column one past the right edge
// flushes every row still open. Rows above ROWS-1 saturate.
// Output channel span: one word per finished row span (span_row,
// span_x_first, span_x_final = column_x - 1), span_last on the final span
// a column causes. A column may cause no span at all.
// Walk: a column occupies the walker through the four walk phases (close
// top, close bottom, open top, open bottom); the walker handles one row per
// cycle, stalled while closing rows if the output stage is not ready.
// A span goes through the start-column RAM read and then the output
// register once its row is walked. Spans issue back to back while the sink
// takes them; a stalled sink holds the output word and, once the read stage
// is full too, the walker, while the next column is still taken once the
// walk is done.
// Reset: asynchronous, clears the handshakes and marks "no previous column".
// The start-column RAM is not cleared; only entries written earlier are read.
module column_edges_to_row_spans_core #(
	parameter int ROWS = ce2rs_pkg::ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ce2rs_col_if.sink     col,
	ce2rs_span_if.source  span
);
	import ce2rs_pkg::*;

	localparam int ADDR_W = $clog2(ROWS);

	// walker -> output stage
	logic      req_valid;
	emit_req_t req;
	logic      req_ready;

	// start-column RAM ports
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [X_W-1:0]    wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [X_W-1:0]    rd_data;

	ce2rs_walker #(.ROWS(ROWS)) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.col       (col),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// per-row span start column
	ce2rs_ram #(.WIDTH(X_W), .DEPTH(ROWS)) u_start_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	ce2rs_emit #(.ROWS(ROWS)) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.span      (span)
	);
endmodule

// ===== rtl/ce2rs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ce2rs_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/ce2rs_walker.sv =====
// Row walker: closes and opens rows between consecutive columns.
`include "column_edges_to_row_spans_core_assert.svh"

module ce2rs_walker #(
	parameter int ROWS = ce2rs_pkg::ROWS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	ce2rs_col_if.sink                col,
	output logic                     req_valid,
	output ce2rs_pkg::emit_req_t     req,
	input  logic                     req_ready,
	output logic                     wr_en,
	output logic [$clog2(ROWS)-1:0]  wr_addr,
	output logic [ce2rs_pkg::X_W-1:0] wr_data
);
	import ce2rs_pkg::*;

	localparam int ADDR_W = $clog2(ROWS);
	localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);

	walk_state_t state_q, state_d;

	logic [ROW_W-1:0]  prev_top_q, prev_bot_q;
	logic              prev_empty_q;
	logic [WALK_W-1:0] t1_q, b1_q, ct_q, cb_q;
	logic [X_W-1:0]    xw_q, xf_q;

	logic              accept;
	logic [ROW_W-1:0]  t2, b2;
	logic [WALK_W-1:0] t1n, b1m;
	logic              c_top, c_bot, c_otop, c_obot;
	logic              last_top, last_bot;

	assign accept = col.valid && col.ready;
	assign t2     = clamp_row(col.top_row, ROW_MAX);
	assign b2     = clamp_row(col.bottom_row, ROW_MAX);

	assign t1n = t1_q + WALK_W'(1);
	assign b1m = b1_q - WALK_W'(1);

	assign c_top  = (t1_q < ct_q) && (t1_q <= b1_q);
	assign c_bot  = (b1_q > cb_q) && (b1_q >= t1_q);
	assign c_otop = (ct_q < t1_q) && (ct_q <= cb_q);
	assign c_obot = (cb_q > b1_q) && (cb_q >= ct_q);

	// nothing left to close after this span?
	assign last_top = !((t1n < ct_q) && (t1n <= b1_q)) && !((b1_q > cb_q) && (b1_q >= t1n));
	assign last_bot = !((b1m > cb_q) && (b1m >= t1_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			WS_IDLE:      if (col.valid) state_d = WS_CLOSE_TOP;
			WS_CLOSE_TOP: if (!c_top)    state_d = WS_CLOSE_BOT;
			WS_CLOSE_BOT: if (!c_bot)    state_d = WS_OPEN_TOP;
			WS_OPEN_TOP:  if (!c_otop)   state_d = WS_OPEN_BOT;
			WS_OPEN_BOT:  if (!c_obot)   state_d = WS_IDLE;
			default:                     state_d = WS_IDLE;
		endcase
	end

	always_comb begin
		col.ready   = 1'b0;
		req_valid   = 1'b0;
		req.row     = t1_q[ROW_W-1:0];
		req.x_final = xf_q;
		req.last    = last_top;
		wr_en       = 1'b0;
		wr_addr     = ct_q[ADDR_W-1:0];
		wr_data     = xw_q;
		case (state_q)
			WS_IDLE: begin
				col.ready = 1'b1;
			end
			WS_CLOSE_TOP: begin
				req_valid = c_top;
			end
			WS_CLOSE_BOT: begin
				req_valid = c_bot;
				req.row   = b1_q[ROW_W-1:0];
				req.last  = last_bot;
			end
			WS_OPEN_TOP: begin
				wr_en = c_otop;
			end
			WS_OPEN_BOT: begin
				wr_en   = c_obot;
				wr_addr = cb_q[ADDR_W-1:0];
			end
			default: begin
				col.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= WS_IDLE;
			prev_top_q   <= '0;
			prev_bot_q   <= '0;
			prev_empty_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (accept) begin
				prev_top_q   <= t2;
				prev_bot_q   <= b2;
				prev_empty_q <= col.column_empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			t1_q <= (col.plane_start || prev_empty_q) ? EMPTY_ROW : {1'b0, prev_top_q};
			b1_q <= (col.plane_start || prev_empty_q) ? '0 : {1'b0, prev_bot_q};
			ct_q <= col.column_empty ? EMPTY_ROW : {1'b0, t2};
			cb_q <= col.column_empty ? '0 : {1'b0, b2};
			xw_q <= col.column_x[X_W-1:0];
			xf_q <= col.column_x[X_W-1:0] - X_W'(1);
		end else begin
			if (state_q == WS_CLOSE_TOP && req_valid && req_ready) t1_q <= t1n;
			if (state_q == WS_CLOSE_BOT && req_valid && req_ready) b1_q <= b1m;
			if (state_q == WS_OPEN_TOP && wr_en) ct_q <= ct_q + WALK_W'(1);
			if (state_q == WS_OPEN_BOT && wr_en) cb_q <= cb_q - WALK_W'(1);
		end
	end

	`CE2RS_ASSERT_HOLDS(a_no_rd_wr_same_cycle, clk, arst_n, !(wr_en && req_valid), "walker reads and writes start memory together")
	`CE2RS_ASSERT_NXT(a_accept_starts_close, clk, arst_n, accept, state_q == WS_CLOSE_TOP, "column accepted without starting the walk")
	`CE2RS_ASSERT_NXT(a_open_keeps_closed_edges, clk, arst_n, state_q == WS_OPEN_TOP, $stable(t1_q) && $stable(b1_q), "closing edges moved while opening rows")
endmodule

// ===== rtl/ce2rs_emit.sv =====
// Output stage: start-column read and span word register.
`include "column_edges_to_row_spans_core_assert.svh"

module ce2rs_emit #(
	parameter int ROWS = ce2rs_pkg::ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  ce2rs_pkg::emit_req_t      req,
	output logic                      req_ready,
	output logic                      rd_en,
	output logic [$clog2(ROWS)-1:0]   rd_addr,
	input  logic [ce2rs_pkg::X_W-1:0] rd_data,
	ce2rs_span_if.source              span
);
	import ce2rs_pkg::*;

	localparam int ADDR_W = $clog2(ROWS);

	logic      s1_valid_q;
	emit_req_t req_s1;
	logic      out_valid_q;
	logic      advance;

	// s1 holds the request while the RAM read is in flight; the RAM output
	// stays put while no new read is issued
	assign advance   = s1_valid_q && (!out_valid_q || span.ready);
	assign req_ready = !s1_valid_q || advance;
	assign rd_en     = req_valid && req_ready;
	assign rd_addr   = req.row[ADDR_W-1:0];

	assign span.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (span.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			req_s1 <= req;
		end
		if (advance) begin
			span.span_row     <= req_s1.row;
			span.span_x_first <= rd_data;
			span.span_x_final <= req_s1.x_final;
			span.span_last    <= req_s1.last;
		end
	end

	`CE2RS_ASSERT_NXT(a_read_fills_s1, clk, arst_n, rd_en, s1_valid_q, "issued read lost its stage")
	`CE2RS_ASSERT_NXT(a_s1_holds, clk, arst_n, s1_valid_q && !advance, s1_valid_q && $stable(req_s1), "stalled read stage changed")
	`CE2RS_ASSERT_NXT(a_s1_moves_to_free_out, clk, arst_n, s1_valid_q && !out_valid_q, out_valid_q, "free output register not filled")
endmodule
